// ===== rtl/core/hph_pkg.sv =====
// shared types and constants of the thermistor polynomial evaluator
`default_nettype none

package hph_pkg;

	localparam int ADC_W     = 12;
	localparam int COEF_W    = 32;
	localparam int FRAC_BITS = 16;
	localparam int NUM_COEFS = 7;
	localparam int NUM_STEPS = NUM_COEFS - 1;
	localparam int IDX_W     = 3;

	// register map, highest power first
	typedef enum logic [IDX_W-1:0] {
		REG_COEF_A6 = 3'd0,
		REG_COEF_A5 = 3'd1,
		REG_COEF_A4 = 3'd2,
		REG_COEF_A3 = 3'd3,
		REG_COEF_A2 = 3'd4,
		REG_COEF_A1 = 3'd5,
		REG_COEF_A0 = 3'd6
	} reg_idx_t;

	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic [NUM_COEFS-1:0][COEF_W-1:0] coef_bank_t;

endpackage

`default_nettype wire

// ===== rtl/core/hph_if.sv =====
// valid/ready channels for converter samples and temperature words
`default_nettype none

interface hph_sample_if import hph_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [ADC_W-1:0] adc_sample;

	modport source (output valid, output adc_sample, input ready);
	modport sink (input valid, input adc_sample, output ready);
endinterface

interface hph_temp_if import hph_pkg::*; ();
	logic  valid;
	logic  ready;
	coef_t temperature;

	modport source (output valid, output temperature, input ready);
	modport sink (input valid, input temperature, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/hph_cfg.sv =====
// coefficient register bank written through a plain write port
`default_nettype none

module hph_cfg import hph_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [IDX_W-1:0]  cfg_index,
	input  wire logic [COEF_W-1:0] cfg_wdata,
	output coef_bank_t             coefs
);

	coef_bank_t coefs_q;

	// indexes past the last coefficient are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coefs_q <= '0;
		end else if (cfg_we && (cfg_index <= REG_COEF_A0)) begin
			coefs_q[cfg_index] <= cfg_wdata;
		end
	end

	assign coefs = coefs_q;

endmodule

`default_nettype wire

// ===== rtl/core/hph_step.sv =====
// one horner step: registered q16.16 multiply, then registered add
`default_nettype none

module hph_step import hph_pkg::*; #(
	parameter int XW = 17
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire coef_t         in_acc,
	input  wire logic [XW-1:0] in_x,
	input  wire coef_t         coef,
	output logic               out_valid,
	input  wire logic          out_ready,
	output coef_t              out_acc,
	output logic [XW-1:0]      out_x
);

	localparam int PW = COEF_W + XW + 1;
	localparam int EW = 2 * COEF_W;

	logic signed [PW-1:0] prod;
	logic signed [EW-1:0] prod_ext;
	logic                 en_s1, en_s2;
	logic                 vld_s1, vld_s2;
	coef_t                prod_s1, acc_s2;
	logic [XW-1:0]        x_s1, x_s2;

	// x is never negative, so it enters with a zero sign bit
	assign prod     = PW'(in_acc) * $signed({1'b0, in_x});
	assign prod_ext = {{(EW - PW){prod[PW-1]}}, prod};

	assign en_s2    = !vld_s2 || out_ready;
	assign en_s1    = !vld_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= in_valid;
			if (en_s2) vld_s2 <= vld_s1;
		end
	end

	// floor shift by the fraction width, low word kept
	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			prod_s1 <= prod_ext[FRAC_BITS+COEF_W-1:FRAC_BITS];
			x_s1    <= in_x;
		end
		if (en_s2 && vld_s1) begin
			acc_s2 <= prod_s1 + coef;
			x_s2   <= x_s1;
		end
	end

	assign out_valid = vld_s2;
	assign out_acc   = acc_s2;
	assign out_x     = x_s2;

endmodule

`default_nettype wire

// ===== rtl/core/thermistor_poly_horner.sv =====
// top level: sixth-degree horner evaluator for thermistor readings
//
// usage
//  - sample channel: one word carries a 12-bit unsigned converter reading;
//    it is shifted left by SAMPLE_SHIFT to form the q16.16 operand x
//  - result channel: one word carries the signed q16.16 temperature,
//    a6*x^6 + ... + a0 by horner's rule, each product floor-shifted by 16,
//    every product and sum wrapping at 32 bits
//  - config port: cfg_we writes cfg_wdata to coefficient cfg_index,
//    0 = a6 down to 6 = a0; other indexes are ignored; write only while idle
//  - pipeline: six steps, each a multiply register and an add register
//  - throughput: one word per cycle unless stalled; the 32x18 signed
//    multiplier of each step (accumulator times zero-extended x) sets
//    the stage depth
//  - reset: all coefficients clear to zero, pipeline empties
//  - stall: a held result blocks only the stages behind it; empty slots
//    keep taking words until all twelve stages hold data, then the sample
//    channel deasserts ready; nothing is lost or repeated
`default_nettype none

module thermistor_poly_horner import hph_pkg::*; #(
	parameter int SAMPLE_SHIFT = 5
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	hph_sample_if.sink             sample,
	hph_temp_if.source             result,
	input  wire logic              cfg_we,
	input  wire logic [IDX_W-1:0]  cfg_index,
	input  wire logic [COEF_W-1:0] cfg_wdata
);

	// operand width after the left shift
	localparam int XW = ADC_W + SAMPLE_SHIFT;

	coef_bank_t    coefs;

	// handshake and data between consecutive steps
	logic          vld_c [NUM_STEPS+1];
	logic          rdy_c [NUM_STEPS+1];
	coef_t         acc_c [NUM_STEPS+1];
	logic [XW-1:0] x_c   [NUM_STEPS+1];

	hph_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.coefs     (coefs)
	);

	// horner seed: the highest coefficient enters with the sample
	assign vld_c[0]     = sample.valid;
	assign sample.ready = rdy_c[0];
	assign acc_c[0]     = coef_t'(coefs[REG_COEF_A6]);
	assign x_c[0]       = XW'(sample.adc_sample) << SAMPLE_SHIFT;

	for (genvar i = 0; i < NUM_STEPS; i++) begin : g_step
		// step i folds in coefficient i+1 of the register map
		hph_step #(
			.XW (XW)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (vld_c[i]),
			.in_ready  (rdy_c[i]),
			.in_acc    (acc_c[i]),
			.in_x      (x_c[i]),
			.coef      (coef_t'(coefs[i+1])),
			.out_valid (vld_c[i+1]),
			.out_ready (rdy_c[i+1]),
			.out_acc   (acc_c[i+1]),
			.out_x     (x_c[i+1])
		);
	end

	// the last step's add register is the output register
	assign result.valid       = vld_c[NUM_STEPS];
	assign rdy_c[NUM_STEPS]   = result.ready;
	assign result.temperature = acc_c[NUM_STEPS];

endmodule

`default_nettype wire

// ===== rtl/core/hph_checker.sv =====
// port-level checks for the horner evaluator, bound to the top level
`default_nettype none

module hph_checker import hph_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [COEF_W-1:0] temperature
);

	// a result word stays offered until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	// a stalled result word keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(temperature))
		else $error("result word changed while stalled");

	// the pipeline comes out of reset empty
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result word present right after reset");

	// input backpressure only when the output is stalled with a full pipe
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("sample channel blocked without an output stall");

endmodule

bind thermistor_poly_horner hph_checker u_hph_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (sample.valid),
	.in_ready    (sample.ready),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.temperature (result.temperature)
);

`default_nettype wire

// ===== verif/tb_top.sv =====
// self-checking testbench of the thermistor horner evaluator: predicts every temperature word
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import hph_pkg::*;

	localparam int SAMPLE_SHIFT = 5;
	// no coefficient lives at this index, so a write to it must change nothing
	localparam logic [IDX_W-1:0] REG_NONE = 3'd7;
	// six multiply and six add registers, plus some margin
	localparam int DRAIN_PAUSE = 16;
	// cycles with no word moving on either channel before the run is abandoned
	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_WORDS = 120;
	// the last phases run with no gaps and no stalls
	localparam int QUIET_PHASES = 3;

	// keeps its own copy of the coefficient bank and the temperatures still owed
	class horner_ledger;
		coef_t coef_bank [NUM_COEFS];
		coef_t pending_temps [$];
		int unsigned errors;

		function new();
			foreach (coef_bank[i]) coef_bank[i] = '0;
			errors = 0;
		endfunction

		// a6 first, then six rounds of floor(acc * x / 2^16) + next coefficient
		function coef_t horner_temp(logic [ADC_W-1:0] adc);
			logic [63:0] x;
			logic [63:0] prod;
			coef_t acc;
			x = 64'(adc) << SAMPLE_SHIFT;
			acc = coef_bank[0];
			for (int i = 1; i < NUM_COEFS; i++) begin
				// sign-extended operands give the right low 64 bits of the signed product
				prod = {{COEF_W{acc[COEF_W-1]}}, acc} * x;
				// bits 47:16 are the floor shift kept to 32 bits, the add wraps
				acc = prod[FRAC_BITS +: COEF_W] + coef_bank[i];
			end
			return acc;
		endfunction

		function void note_sample(logic [ADC_W-1:0] adc);
			pending_temps.push_back(horner_temp(adc));
		endfunction

		function void check_temp(coef_t actual);
			coef_t want;
			if (pending_temps.size() == 0) begin
				errors++;
				$display("%0t: temperature word with none owed: expected none, actual %h",
					$time, actual);
				return;
			end
			want = pending_temps.pop_front();
			if (want !== actual) begin
				errors++;
				$display("%0t: temperature mismatch: expected %h (%0d), actual %h (%0d)",
					$time, want, want, actual, actual);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [COEF_W-1:0] cfg_wdata;

	hph_sample_if sample_ch ();
	hph_temp_if temp_ch ();

	horner_ledger ledger = new();

	// coefficient bank that the next load writes, a6 first
	coef_t next_coefs [NUM_COEFS];
	// chance in percent of a gap before a sample word, and of a stall per cycle
	int gap_pct;
	int stall_pct;
	int idle_cycles = 0;

	thermistor_poly_horner #(
		.SAMPLE_SHIFT(SAMPLE_SHIFT)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample_ch),
		.result(temp_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// both monitors see the values from just before the edge, since all drivers use nba
	always @(posedge clk) begin
		if (sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1)
			ledger.note_sample(sample_ch.adc_sample);
		if (temp_ch.valid === 1'b1 && temp_ch.ready === 1'b1)
			ledger.check_temp(temp_ch.temperature);

		// watchdog: any word moving on either side counts as progress
		if ((sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1) ||
				(temp_ch.valid === 1'b1 && temp_ch.ready === 1'b1)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// result side: ready driven by nba, held low for random stall bursts
	initial begin
		temp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (stall_pct != 0 && $urandom_range(99, 0) < stall_pct) begin
				temp_ch.ready <= 1'b0;
				repeat ($urandom_range(7, 1)) @(posedge clk);
			end else begin
				temp_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// writes the whole bank, then a stray write to the empty index
	task automatic load_coefs();
		for (int i = 0; i < NUM_COEFS; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= reg_idx_t'(i);
			cfg_wdata <= next_coefs[i];
			ledger.coef_bank[i] = next_coefs[i];
			@(posedge clk);
		end
		// last, so that an index aliasing onto a real register shows up
		cfg_index <= REG_NONE;
		cfg_wdata <= $urandom();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// valid stays high across back-to-back words; lowered only for a gap
	task automatic send_sample(input logic [ADC_W-1:0] adc);
		if (gap_pct != 0 && $urandom_range(99, 0) < gap_pct) begin
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(7, 1)) @(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.adc_sample <= adc;
		do @(posedge clk); while (sample_ch.ready !== 1'b1);
	endtask

	// wait for every owed word, then let the pipeline empty before touching the bank
	task automatic settle();
		sample_ch.valid <= 1'b0;
		// an edge first, so the monitor has logged the last accepted sample
		@(posedge clk);
		while (ledger.pending_temps.size() != 0) @(posedge clk);
		repeat (DRAIN_PAUSE) @(posedge clk);
	endtask

	initial begin
		int pick;
		logic [ADC_W-1:0] adc;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		sample_ch.valid = 1'b0;
		sample_ch.adc_sample = '0;
		gap_pct = 0;
		stall_pct = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// coefficients straight out of reset are all zero, so every word is zero
		send_sample(12'd0);
		send_sample(12'hfff);
		send_sample(12'd1);
		send_sample(12'h800);
		settle();

		// every coefficient at the positive extreme: products and sums wrap
		foreach (next_coefs[i]) next_coefs[i] = 32'h7fff_ffff;
		load_coefs();
		send_sample(12'd0);
		send_sample(12'hfff);
		send_sample(12'haaa);
		send_sample(12'h555);
		settle();

		// every coefficient at the negative extreme
		foreach (next_coefs[i]) next_coefs[i] = 32'h8000_0000;
		load_coefs();
		send_sample(12'd0);
		send_sample(12'hfff);
		send_sample(12'haaa);
		send_sample(12'h555);
		settle();

		// tiny negative a6: small negative products must floor to -1, not to zero
		foreach (next_coefs[i]) next_coefs[i] = '0;
		next_coefs[REG_COEF_A6] = 32'hffff_ffff;
		load_coefs();
		send_sample(12'd1);
		send_sample(12'd7);
		send_sample(12'hfff);
		settle();

		// plain line: x - 20.0, checks coefficient order and the sample shift
		foreach (next_coefs[i]) next_coefs[i] = '0;
		next_coefs[REG_COEF_A1] = 32'h0001_0000;
		next_coefs[REG_COEF_A0] = -32'sd1310720;
		load_coefs();
		send_sample(12'hfff);
		send_sample(12'h800);
		send_sample(12'd0);
		settle();

		// random banks, each followed by a stream of random samples
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			foreach (next_coefs[i]) begin
				pick = $urandom_range(5, 0);
				case (pick)
					0: next_coefs[i] = $urandom();
					// around +-8.0, the range real thermistor fits live in
					1: next_coefs[i] = coef_t'($urandom_range(32'h000f_ffff, 0)) - 32'sh0008_0000;
					// anywhere within about +-2.0, down to single lsbs
					2: next_coefs[i] = coef_t'($urandom_range(32'h0003_ffff, 0)) - 32'sh0002_0000;
					3: next_coefs[i] = 32'h7fff_ffff;
					4: next_coefs[i] = 32'h8000_0000;
					default: next_coefs[i] = '0;
				endcase
			end
			load_coefs();

			if (p >= RANDOM_PHASES - QUIET_PHASES) begin
				gap_pct = 0;
				stall_pct = 0;
			end else begin
				pick = $urandom_range(2, 0);
				gap_pct = (pick == 0) ? 0 : (pick == 1) ? 15 : 40;
				pick = $urandom_range(2, 0);
				stall_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : 30;
			end

			for (int n = 0; n < PHASE_WORDS; n++) begin
				// end points of the converter range now and then
				if ($urandom_range(15, 0) == 0)
					adc = $urandom_range(1, 0) ? 12'hfff : 12'd0;
				else
					adc = ADC_W'($urandom_range(4095, 0));
				send_sample(adc);
			end
			settle();
		end

		if (ledger.errors == 0 && ledger.pending_temps.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
